### hdl/cbz_pkg.sv
// Package of the cubic Bezier curve unit: sizes, codes, the evaluation
// step table and the command and status types between controller and datapath.
// Depends on nothing.
package cbz_pkg;

  localparam int SEARCH_STEPS = 100;
  localparam int MAX_SAMPLES  = 64;

  // Largest number of grid intervals and the widths that follow from it.
  localparam int DMAX = (SEARCH_STEPS > MAX_SAMPLES - 1) ? SEARCH_STEPS : MAX_SAMPLES - 1;
  localparam int DW   = $clog2(DMAX + 1);
  localparam int RW   = DW + 2;

  localparam int TW = 17;
  localparam logic [TW-1:0] ONE_T = 17'h10000;

  // The grid step is 2*65536 / (2*d), found by a restoring divider.
  localparam int NW = 18;
  localparam logic [NW-1:0] DIV_NUM = 18'h20000;
  localparam int CW = 5;
  localparam logic [CW-1:0] DIV_LAST = CW'(NW - 1);

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 88;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_START  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL_A = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CTRL_B = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 3'd4;

  // De Casteljau on a rotating set of four points: a set bit is a lerp,
  // a clear bit is a plain rotation.
  localparam logic [8:0] STEP_LERP = 9'b100110111;
  localparam logic [3:0] LAST_STEP = 4'd8;

  typedef enum logic [1:0] {
    OP_EVAL = 2'd0,
    OP_FIND = 2'd1,
    OP_DISC = 2'd2,
    OP_NONE = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV,
    ST_LOAD,
    ST_MUL,
    ST_ADD,
    ST_ROT,
    ST_POST,
    ST_BEST
  } state_e;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic load;
    logic mul;
    logic lerp;
    logic rot;
    logic keep;
    logic first;
    logic emit_pt;
    logic emit_last;
    logic emit_best;
    logic advance;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic k_end;
  } sts_t;

endpackage

### hdl/cbz_ctrl.sv
// Controller of the cubic Bezier curve unit: sequences division, the nine
// evaluation steps per point, the search and the sample loop.
// Depends on cbz_pkg.
module cbz_ctrl
  import cbz_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_opcode_i,
  output logic       in_ready_o,
  input  sts_t       sts_i,
  output cmd_t       cmd_o
);

  state_e         state_q, state_d;
  op_e            op_q, op_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [3:0]     step_q, step_d;
  logic           first_q, first_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      op_q    <= OP_EVAL;
      cnt_q   <= '0;
      step_q  <= '0;
      first_q <= 1'b0;
    end else begin
      state_q <= state_d;
      op_q    <= op_d;
      cnt_q   <= cnt_d;
      step_q  <= step_d;
      first_q <= first_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    cnt_d      = cnt_q;
    step_d     = step_q;
    first_d    = first_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          op_d         = op_e'(in_opcode_i);
          cnt_d        = '0;
          first_d      = 1'b1;
          unique case (op_e'(in_opcode_i))
            OP_EVAL:          state_d = ST_LOAD;
            OP_FIND, OP_DISC: state_d = ST_DIV;
            default:          state_d = ST_IDLE;
          endcase
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + CW'(1);
        if (cnt_q == DIV_LAST) begin
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd_o.load = 1'b1;
        step_d     = '0;
        state_d    = STEP_LERP[0] ? ST_MUL : ST_ROT;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_ADD;
      end
      ST_ADD, ST_ROT: begin
        cmd_o.lerp = (state_q == ST_ADD);
        cmd_o.rot  = (state_q == ST_ROT);
        step_d     = step_q + 4'd1;
        if (step_q == LAST_STEP) begin
          state_d = ST_POST;
        end else begin
          state_d = STEP_LERP[step_q + 4'd1] ? ST_MUL : ST_ROT;
        end
      end
      ST_POST: begin
        if (op_q == OP_FIND) begin
          cmd_o.keep  = 1'b1;
          cmd_o.first = first_q;
          first_d     = 1'b0;
          if (sts_i.k_end) begin
            state_d = ST_BEST;
          end else begin
            cmd_o.advance = 1'b1;
            state_d       = ST_LOAD;
          end
        end else if (sts_i.out_free) begin
          cmd_o.emit_pt   = 1'b1;
          cmd_o.emit_last = (op_q != OP_DISC) || sts_i.k_end;
          if (cmd_o.emit_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.advance = 1'b1;
            state_d       = ST_LOAD;
          end
        end
      end
      ST_BEST: begin
        if (sts_i.out_free) begin
          cmd_o.emit_best = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.emit_pt || cmd_o.emit_best) |-> sts_i.out_free)
    else $error("result written while output register is occupied");

  a_emit_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_o.emit_pt && cmd_o.emit_best))
    else $error("two results written in one cycle");

  a_div_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (cnt_q <= DIV_LAST))
    else $error("divider ran past its length");

  a_find_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.keep |-> (op_q == OP_FIND))
    else $error("search compare outside a find item");

endmodule

### hdl/cbz_dpath.sv
// Datapath of the cubic Bezier curve unit: configuration registers, grid
// divider and stepper, shared lerp pair, search compare and output register.
// Depends on cbz_pkg.
module cbz_dpath
  import cbz_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output sts_t                  sts_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic [IN_DATA_W-1:0]  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_DATA_W-1:0] out_data_o,
  output logic                  out_last_o
);

  logic [CFG_DATA_W-1:0] pt_q [4];
  logic [6:0]            cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) pt_q[i] <= '0;
      cnt_q <= 7'd64;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_START:  pt_q[0] <= cfg_data_i;
        REG_CTRL_A: pt_q[1] <= cfg_data_i;
        REG_CTRL_B: pt_q[2] <= cfg_data_i;
        REG_END:    pt_q[3] <= cfg_data_i;
        REG_COUNT:  cnt_q   <= cfg_data_i[6:0];
        default:    ;
      endcase
    end
  end

  // Decode of the accepted item.
  op_e               in_op;
  logic [TW-1:0]     in_t, t_sat;
  logic signed [31:0] in_tx;
  logic [6:0]        n_cl;
  logic [DW-1:0]     d_acc;

  assign in_op = op_e'(in_data_i[1:0]);
  assign in_t  = in_data_i[18:2];
  assign in_tx = in_data_i[50:19];
  assign t_sat = (in_t > ONE_T) ? ONE_T : in_t;

  always_comb begin
    if (cnt_q < 7'd2) begin
      n_cl = 7'd2;
    end else if (cnt_q > 7'(MAX_SAMPLES)) begin
      n_cl = 7'(MAX_SAMPLES);
    end else begin
      n_cl = cnt_q;
    end
    d_acc = (in_op == OP_FIND) ? DW'(SEARCH_STEPS) : DW'(n_cl - 7'd1);
  end

  // Grid: t_k = round(k / d), stepped by quotient and remainder of 1/d.
  logic [DW-1:0]      d_q, k_q;
  logic signed [31:0] tgt_q;
  logic [RW-1:0]      rem_q, tr_q, d2, trial, tr_sum;
  logic [NW-1:0]      num_q, quo_q;
  logic [TW-1:0]      tq_q;

  assign d2     = RW'({d_q, 1'b0});
  assign trial  = {rem_q[RW-2:0], num_q[NW-1]};
  assign tr_sum = tr_q + rem_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      d_q   <= d_acc;
      tgt_q <= in_tx;
      k_q   <= '0;
      rem_q <= '0;
      num_q <= DIV_NUM;
      quo_q <= '0;
      tr_q  <= RW'(d_acc);
      tq_q  <= (in_op == OP_EVAL) ? t_sat : '0;
    end else begin
      if (cmd_i.div_step) begin
        num_q <= {num_q[NW-2:0], 1'b0};
        if (trial >= d2) begin
          rem_q <= trial - d2;
          quo_q <= {quo_q[NW-2:0], 1'b1};
        end else begin
          rem_q <= trial;
          quo_q <= {quo_q[NW-2:0], 1'b0};
        end
      end
      if (cmd_i.advance) begin
        k_q <= k_q + DW'(1);
        if (tr_sum >= d2) begin
          tr_q <= tr_sum - d2;
          tq_q <= tq_q + quo_q[TW-1:0] + TW'(1);
        end else begin
          tr_q <= tr_sum;
          tq_q <= tq_q + quo_q[TW-1:0];
        end
      end
    end
  end

  // Rotating point set and the lerp pair, product registered.
  logic signed [31:0] px_q [4];
  logic signed [31:0] py_q [4];
  logic signed [50:0] prx_q, pry_q, rndx, rndy;
  logic signed [32:0] dfx, dfy;
  logic signed [31:0] resx, resy;

  assign dfx  = $signed({px_q[1][31], px_q[1]}) - $signed({px_q[0][31], px_q[0]});
  assign dfy  = $signed({py_q[1][31], py_q[1]}) - $signed({py_q[0][31], py_q[0]});
  assign rndx = (prx_q + 51'sd32768) >>> 16;
  assign rndy = (pry_q + 51'sd32768) >>> 16;
  assign resx = px_q[0] + rndx[31:0];
  assign resy = py_q[0] + rndy[31:0];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int i = 0; i < 4; i++) begin
        px_q[i] <= pt_q[i][63:32];
        py_q[i] <= pt_q[i][31:0];
      end
    end else if (cmd_i.lerp || cmd_i.rot) begin
      for (int i = 0; i < 3; i++) begin
        px_q[i] <= px_q[i+1];
        py_q[i] <= py_q[i+1];
      end
      px_q[3] <= cmd_i.lerp ? resx : px_q[0];
      py_q[3] <= cmd_i.lerp ? resy : py_q[0];
    end
    if (cmd_i.mul) begin
      prx_q <= dfx * $signed({1'b0, tq_q});
      pry_q <= dfy * $signed({1'b0, tq_q});
    end
  end

  // Nearest-x search; only a strictly smaller distance replaces the best.
  logic signed [32:0] dd;
  logic [32:0]        dx_abs, bd_q;
  logic signed [31:0] bx_q, by_q;
  logic [TW-1:0]      bt_q;

  assign dd     = $signed({tgt_q[31], tgt_q}) - $signed({px_q[3][31], px_q[3]});
  assign dx_abs = dd[32] ? 33'(-dd) : 33'(dd);

  always_ff @(posedge clk_i) begin
    if (cmd_i.keep && (cmd_i.first || dx_abs < bd_q)) begin
      bd_q <= dx_abs;
      bx_q <= px_q[3];
      by_q <= py_q[3];
      bt_q <= tq_q;
    end
  end

  // Output register.
  logic               ov_q;
  logic signed [31:0] ox_q, oy_q;
  logic [TW-1:0]      ot_q;
  logic               ol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.emit_pt || cmd_i.emit_best) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_pt) begin
      ox_q <= px_q[3];
      oy_q <= py_q[3];
      ot_q <= tq_q;
      ol_q <= cmd_i.emit_last;
    end else if (cmd_i.emit_best) begin
      ox_q <= bx_q;
      oy_q <= by_q;
      ot_q <= bt_q;
      ol_q <= 1'b1;
    end
  end

  assign out_valid_o    = ov_q;
  assign out_data_o     = {7'b0, ot_q, oy_q, ox_q};
  assign out_last_o     = ol_q;
  assign sts_o.out_free = !ov_q || out_ready_i;
  assign sts_o.k_end    = (k_q == d_q);

  a_t_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_pt |-> (tq_q <= ONE_T))
    else $error("curve parameter above one");

  a_k_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.advance |-> (k_q < d_q))
    else $error("grid index stepped past the last interval");

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.advance |-> (tr_q < d2))
    else $error("grid remainder out of range");

endmodule

### hdl/cubic_bezier_curve_unit.sv
// Cubic Bezier curve unit: evaluate, nearest-x search and discretize.
// Each point runs load, six lerps (a multiply, then an add), three rotations and post;
// find and discretize first run the grid divider. Evaluate computes one point, find 101
// and discretize n; output stalls can hold any item. One item at a time; a waiting result
// lets the next start. Reset clears control, points to zero and sample_count to 64.
// Depends on cbz_pkg.
module cubic_bezier_curve_unit
  import cbz_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // opcode, t_in, target_x
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // point_x, point_y, t_out
  output logic                  m_axis_tlast,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  cbz_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_opcode_i (s_axis_tdata[1:0]),
    .in_ready_o  (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  cbz_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule
